[hw/rtl/nns3d_pkg.sv]
// Shared types, constants and helpers for the 3-D nearest-neighbour search block.
package nns3d_pkg;
    localparam int POINT_CAPACITY_DEF = 1024;
    localparam int MAX_NEIGHBOURS_DEF = 64;
    localparam int COORD_BITS_DEF     = 20;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 20;
    localparam int ID_W     = 20;
    localparam int KCNT_W   = 7;
    localparam int DIST_W   = 42;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_KNN    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RADIUS = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [ID_W-1:0]   point_id;
        logic              last_point;
        logic [KCNT_W-1:0] k_count;
        logic [DIST_W-1:0] radius_sq;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   neighbour_id;
        logic [DIST_W-1:0] dist_sq;
        logic              found;
        logic              last;
        logic              truncated;
    } t_out_item;
endpackage

[hw/rtl/nns3d_if.sv]
// Valid/ready channel interfaces for the input and result beats.
interface nns3d_in_if;
    import nns3d_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nns3d_out_if;
    import nns3d_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/nns3d_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module nns3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/nns3d_dist.sv]
// Pipelined squared-distance unit: difference, per-axis square, sum with saturation.
module nns3d_dist #(
    parameter int COORD_BITS = nns3d_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_valid,
    input  logic [nns3d_pkg::POS_W-1:0]       i_qx,
    input  logic [nns3d_pkg::POS_W-1:0]       i_qy,
    input  logic [nns3d_pkg::POS_W-1:0]       i_qz,
    input  logic [COORD_BITS-1:0]             i_px,
    input  logic [COORD_BITS-1:0]             i_py,
    input  logic [COORD_BITS-1:0]             i_pz,
    output logic                              o_valid,
    output logic [nns3d_pkg::DIST_W-1:0]      o_dist
);
    import nns3d_pkg::*;
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW;

    logic [DW-1:0] r_ax, r_ay, r_az;
    logic [SW-1:0] r_sx, r_sy, r_sz;
    logic          r_v1, r_v2, r_v3;
    logic [SW+1:0] w_sum;
    logic signed [DW-1:0] w_dx, w_dy, w_dz;

    // sign-extend, subtract, take magnitude
    assign w_dx = DW'($signed(COORD_BITS'(i_qx))) - DW'($signed(i_px));
    assign w_dy = DW'($signed(COORD_BITS'(i_qy))) - DW'($signed(i_py));
    assign w_dz = DW'($signed(COORD_BITS'(i_qz))) - DW'($signed(i_pz));
    assign w_sum = (SW+2)'(r_sx) + (SW+2)'(r_sy) + (SW+2)'(r_sz);

    always_ff @(posedge i_clk) begin
        r_v1 <= i_valid;
        r_v2 <= r_v1;
        r_v3 <= r_v2;
        r_ax <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
        r_ay <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
        r_az <= w_dz[DW-1] ? DW'(-w_dz) : DW'(w_dz);
        r_sx <= SW'(r_ax) * SW'(r_ax);
        r_sy <= SW'(r_ay) * SW'(r_ay);
        r_sz <= SW'(r_az) * SW'(r_az);
        // saturate to the result width
        if ((SW + 2) > DIST_W && (w_sum >> DIST_W) != '0) begin
            o_dist <= DIST_MAX;
        end else begin
            o_dist <= DIST_W'(w_sum);
        end
    end
    assign o_valid = r_v3;
endmodule

[hw/rtl/nearest_neighbour_search_3d.sv]
// Top level of the 3-D nearest-neighbour search block.
// Input channel i_in: one beat is a load (func 0), a k-nearest query (func 1)
// or a radius query (func 2). Result channel o_out gives the answer beats;
// last marks the final beat of a query, found clear marks an empty answer.
// A load gives no result; loads can follow back to back.
// A query reads the stored points from the point memory one at a time: each
// read waits until the previous point has left the 3-stage distance pipe.
// Each candidate that passes is taken from the candidate queue and merged
// into a sorted best list by walking from the tail, one list position per
// read phase and compare phase; the scan pauses meanwhile. The list is then
// streamed out, each entry read from the list before it is presented, or a
// single beat for an empty answer. The serialized point reads and the list
// insertion set the rate. Reset empties the set and closes it; the memories
// need no clearing. When the receiver stalls, the result register holds its
// beat and the block waits; no new beat is taken until the query has
// delivered all results.
module nearest_neighbour_search_3d #(
    parameter int POINT_CAPACITY = nns3d_pkg::POINT_CAPACITY_DEF,
    parameter int MAX_NEIGHBOURS = nns3d_pkg::MAX_NEIGHBOURS_DEF,
    parameter int COORD_BITS     = nns3d_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nns3d_in_if.sink    i_in,
    nns3d_out_if.source o_out
);
    import nns3d_pkg::*;
    localparam int AW = $clog2(POINT_CAPACITY);
    localparam int CW = $clog2(POINT_CAPACITY + 1);
    localparam int LW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int NW = $clog2(MAX_NEIGHBOURS + 1);
    localparam int PW = 3 * COORD_BITS + ID_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]  r_state;
    logic [CW-1:0] r_count;
    logic        r_closed;
    t_in_item    r_q;
    logic [NW-1:0] r_k;
    logic [CW-1:0] r_rd;       // next slot to read
    logic [CW-1:0] r_slot_p1, r_slot_p2, r_slot_p3, r_slot_p4; // slot trackers
    logic        r_rv;
    logic [NW-1:0] r_n;
    logic        r_trunc;
    logic [NW-1:0] r_pos;      // insertion cursor walking down
    logic [DIST_W-1:0] r_cd;
    logic [ID_W-1:0]   r_cid;
    logic [CW-1:0]     r_cs;
    logic [NW-1:0] r_oi;
    logic [NW-1:0] r_tot;

    // candidate FIFO between the pipe and the list merge
    localparam int FD = 8;
    logic [DIST_W+ID_W+CW-1:0] r_fifo [FD];
    logic [3:0] r_fw, r_fr;

    // point memory
    logic [PW-1:0] w_wdata, w_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [CW-1:0] w_base;
    assign w_base  = r_closed ? '0 : r_count;
    assign w_we    = (r_state == ST_IDLE) && i_in.valid && i_in.ready &&
                     (i_in.data.func == FUNC_LOAD) && (w_base < CW'(POINT_CAPACITY));
    assign w_waddr = AW'(w_base);
    assign w_wdata = {COORD_BITS'(i_in.data.pos_x), COORD_BITS'(i_in.data.pos_y),
                      COORD_BITS'(i_in.data.pos_z), i_in.data.point_id};

    nns3d_ram #(.WIDTH(PW), .DEPTH(POINT_CAPACITY)) u_pts (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(AW'(r_rd)), .o_rdata(w_rdata));

    // distance pipe; id rides alongside
    logic              w_dv;
    logic [DIST_W-1:0] w_d;
    logic [ID_W-1:0]   r_id1, r_id2, r_id3;
    logic [3:0]        r_pv;
    logic [COORD_BITS-1:0] w_px, w_py, w_pz;
    assign {w_px, w_py, w_pz} = w_rdata[PW-1:ID_W];

    nns3d_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .i_clk(i_clk), .i_valid(r_rv), .i_qx(r_q.pos_x), .i_qy(r_q.pos_y),
        .i_qz(r_q.pos_z), .i_px(w_px), .i_py(w_py), .i_pz(w_pz),
        .o_valid(w_dv), .o_dist(w_d));

    // best list memory: distance and id/slot packed in one word
    localparam int BW = DIST_W + ID_W + CW;
    logic          r_bwe;
    logic [LW-1:0] r_bwa;
    logic [BW-1:0] r_bwd;
    logic [LW-1:0] w_bra;
    logic [BW-1:0] w_brd;
    nns3d_ram #(.WIDTH(BW), .DEPTH(MAX_NEIGHBOURS)) u_best (
        .i_clk(i_clk), .i_we(r_bwe), .i_waddr(r_bwa), .i_wdata(r_bwd),
        .i_raddr(w_bra), .o_rdata(w_brd));

    logic w_knn, w_accept_cand, w_fifo_empty, w_pipe_busy;
    logic [NW-1:0] w_cap;
    assign w_knn = (r_q.func == FUNC_KNN);
    assign w_cap = w_knn ? r_k : NW'(MAX_NEIGHBOURS);
    assign w_accept_cand = w_dv && (w_knn ? (r_id3 != r_q.point_id) : (w_d <= r_q.radius_sq));
    assign w_fifo_empty = (r_fw == r_fr);
    assign w_pipe_busy = r_rv || (r_pv != '0) || (r_rd < r_count);

    // issue a read when the fifo has room for all in flight
    logic w_issue;
    assign w_issue = (r_state == ST_SCAN) && (r_rd < r_count) && ((r_fw - r_fr) < 4'd3) &&
                     (r_pv == '0) && !r_rv;

    // insertion walks from the tail: read entry pos-1, compare, shift down
    // one position per read phase and compare phase (r_ph), reading ahead through w_bra
    logic r_ph; // 0 issue read, 1 compare
    logic w_less; // stored entry (pos-1) less than candidate
    logic [DIST_W-1:0] w_ed;
    logic [ID_W-1:0]   w_eid;
    logic [CW-1:0]     w_es;
    assign {w_ed, w_eid, w_es} = w_brd;
    always_comb begin
        if (w_knn && w_ed != r_cd) w_less = w_ed < r_cd;
        else if (w_eid != r_cid)   w_less = w_eid < r_cid;
        else                       w_less = w_es < r_cs;
    end
    assign w_bra = (r_state == ST_OUT) ? LW'(r_oi) : LW'(r_pos - NW'(1));

    // write the best list when placing or shifting inside the cap
    logic w_bwe;
    assign w_bwe = (r_state == ST_INS) && (w_cap != '0) &&
                   ((r_pos == '0) || (r_ph && (r_pos < w_cap)));

    logic r_ov;
    t_out_item r_od;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;
    assign i_in.ready  = (r_state == ST_IDLE) && !r_ov;

    logic w_start_out;
    logic w_present;
    assign w_present = (r_state == ST_OUT) && (!r_ov || o_out.ready) &&
                       ((r_n == '0) || r_ph);

    always_ff @(posedge i_clk) begin
        r_id1 <= w_rdata[ID_W-1:0];
        r_id2 <= r_id1; r_id3 <= r_id2;
        r_slot_p2 <= r_slot_p1; r_slot_p3 <= r_slot_p2; r_slot_p4 <= r_slot_p3;
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_count <= '0; r_closed <= 1'b1;
            r_ov <= 1'b0; r_rv <= 1'b0; r_pv <= '0; r_fw <= '0; r_fr <= '0;
            r_rd <= '0; r_bwe <= 1'b0;
        end else begin
            r_rv  <= w_issue;
            r_pv  <= {r_pv[2:0], r_rv};
            r_bwe <= w_bwe;
            // hold the result beat until it is taken
            if (w_present) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            // push accepted candidates
            if (w_accept_cand) begin
                r_fifo[r_fw[2:0]] <= {w_d, r_id3, r_slot_p4};
                r_fw <= r_fw + 4'd1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_q <= i_in.data;
                        r_k <= (i_in.data.k_count > KCNT_W'(MAX_NEIGHBOURS)) ?
                               NW'(MAX_NEIGHBOURS) : NW'(i_in.data.k_count);
                        r_n <= '0; r_trunc <= 1'b0; r_rd <= '0; r_ph <= 1'b0;
                        r_fw <= '0; r_fr <= '0; r_pos <= '0;
                        case (i_in.data.func)
                            FUNC_LOAD: begin
                                r_count <= (w_base < CW'(POINT_CAPACITY)) ?
                                           w_base + CW'(1) : w_base;
                                r_closed <= i_in.data.last_point;
                            end
                            FUNC_KNN, FUNC_RADIUS: r_state <= ST_SCAN;
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN: begin
                    // advance the read slot
                    if (w_issue) begin
                        r_slot_p1 <= r_rd;
                        r_rd <= r_rd + CW'(1);
                    end
                    if (!w_fifo_empty && !w_accept_cand) begin
                        {r_cd, r_cid, r_cs} <= r_fifo[r_fr[2:0]];
                        r_fr <= r_fr + 4'd1;
                        // start the walk at the list tail, or at the cap when the list is full
                        r_pos <= (r_n < w_cap) ? r_n : w_cap;
                        r_ph  <= 1'b0;
                        r_state <= ST_INS;
                    end else if (!w_pipe_busy && w_fifo_empty && !w_accept_cand) begin
                        r_oi <= w_knn ? r_n - NW'(1) : '0;
                        r_state <= ST_OUT;
                        r_ph <= 1'b0;
                    end
                end
                ST_INS: begin
                    if (w_cap == '0) begin
                        r_state <= ST_SCAN;
                    end else if (r_pos == '0) begin
                        // place at head
                        if (r_n < w_cap) r_n <= r_n + NW'(1);
                        r_bwa <= '0; r_bwd <= {r_cd, r_cid, r_cs};
                        r_state <= ST_SCAN;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (w_less) begin
                            // candidate goes at r_pos, if inside the cap
                            if (r_pos < w_cap) begin
                                r_bwa <= LW'(r_pos);
                                r_bwd <= {r_cd, r_cid, r_cs};
                                if (r_n < w_cap) r_n <= r_n + NW'(1);
                            end
                            r_state <= ST_SCAN;
                        end else begin
                            // shift entry pos-1 down to pos
                            if (r_pos < w_cap) begin
                                r_bwa <= LW'(r_pos); r_bwd <= w_brd;
                            end
                            r_pos <= r_pos - NW'(1);
                        end
                    end
                end
                ST_OUT: begin
                    // read entry r_oi, then present it
                    if (r_n == '0) begin
                        if (w_present) begin
                            r_od <= '{neighbour_id: '0, dist_sq: '0, found: 1'b0,
                                      last: 1'b1, truncated: 1'b0};
                            r_state <= ST_IDLE;
                        end
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_present) begin
                        r_od <= '{neighbour_id: w_eid, dist_sq: w_ed, found: 1'b1,
                                  last: w_start_out, truncated: r_trunc};
                        r_ph <= 1'b0;
                        if (w_start_out) r_state <= ST_IDLE;
                        else r_oi <= w_knn ? r_oi - NW'(1) : r_oi + NW'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // radius overflow count: more matches than the list holds
            if (!w_knn && w_accept_cand && r_state != ST_IDLE && r_tot >= NW'(MAX_NEIGHBOURS))
                r_trunc <= 1'b1;
        end
    end

    // count radius matches to detect truncation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == ST_IDLE)) begin
            r_tot <= '0;
        end else if (w_accept_cand && r_tot < NW'(MAX_NEIGHBOURS)) begin
            r_tot <= r_tot + NW'(1);
        end
    end

    assign w_start_out = w_knn ? (r_oi == '0) : (r_oi == r_n - NW'(1));
endmodule
